@@ src/npfvs_pkg.sv @@
// Package for the nested page fault view switch.
// Holds sizes, command and status codes and shared types; no dependencies.
`timescale 1ns / 1ps
package npfvs_pkg;

  localparam int WATCH_ENTRIES = 16;
  localparam int CPU_COUNT     = 64;
  localparam int STORM_LIMIT   = 16;

  localparam int CMD_W   = 2;
  localparam int CPU_W   = 6;
  localparam int ADDR_W  = 52;
  localparam int OFFS_W  = 12;
  localparam int PAGE_W  = ADDR_W - OFFS_W;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(STORM_LIMIT + 1);
  localparam int CPU_IW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int WIDX_W  = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

  localparam logic [CMD_W-1:0] CMD_FAULT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // Per-processor record kept in the state RAM
  typedef struct packed {
    logic              view;
    logic [ADDR_W-1:0] last_addr;
    logic [CNT_W-1:0]  cnt;
  } cpu_ent_t;

  // Lookup status from the watched page table
  typedef struct packed {
    logic hit;
    logic empty;
    logic full;
  } watch_look_t;

  // Edit requests into the watched page table
  typedef struct packed {
    logic add;
    logic remove;
  } watch_edit_t;

endpackage

@@ src/npfvs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module npfvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/npfvs_watch.sv @@
// Watched page table: parallel page compare, first-free slot pick, add/remove.
// Depends on npfvs_pkg.
`timescale 1ns / 1ps
module npfvs_watch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [npfvs_pkg::PAGE_W-1:0] page,
  input  npfvs_pkg::watch_edit_t       edit,
  output npfvs_pkg::watch_look_t       look
);

  logic [npfvs_pkg::WATCH_ENTRIES-1:0] vld_r;
  logic [npfvs_pkg::PAGE_W-1:0]        page_r [npfvs_pkg::WATCH_ENTRIES];

  logic [npfvs_pkg::WATCH_ENTRIES-1:0] hit_vec;
  logic [npfvs_pkg::WIDX_W-1:0]        hit_idx;
  logic [npfvs_pkg::WIDX_W-1:0]        free_idx;
  logic                                free_found;

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < npfvs_pkg::WATCH_ENTRIES; i++) begin
      hit_vec[i] = vld_r[i] && (page_r[i] == page);
      if (hit_vec[i]) begin
        hit_idx = npfvs_pkg::WIDX_W'(i);
      end
    end
    for (int i = npfvs_pkg::WATCH_ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_idx   = npfvs_pkg::WIDX_W'(i);
        free_found = 1'b1;
      end
    end
    look.hit   = |hit_vec;
    look.empty = ~|vld_r;
    look.full  = ~free_found;
  end

  // Add lands in the lowest free slot; remove drops the matching slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (edit.add && !look.hit && free_found) begin
      vld_r[free_idx] <= 1'b1;
    end else if (edit.remove && look.hit) begin
      vld_r[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (edit.add && !look.hit && free_found) begin
      page_r[free_idx] <= page;
    end
  end

endmodule

@@ src/nested_page_fault_view_switch.sv @@
// Nested page fault view switch, top level.
// Flow: the accepted word's per-CPU state RAM read, then the update in S_EXEC into the output register.
// One word at a time: a new word is taken only in S_IDLE, after the state RAM read and write-back.
// Further stalls only while an earlier result still waits in the output register.
// Reset: synchronous, active low; clears the watched table and the per-CPU valid bits,
// so every processor reads as primary view, zero address, zero repeat count.
// Depends on npfvs_pkg, npfvs_ram, npfvs_watch.
`timescale 1ns / 1ps
module nested_page_fault_view_switch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [npfvs_pkg::CMD_W-1:0]  in_command,
  input  logic [npfvs_pkg::CPU_W-1:0]  in_cpu_index,
  input  logic [npfvs_pkg::ADDR_W-1:0] in_guest_address,
  input  logic                         in_fault_is_fetch,
  input  logic                         in_fault_is_write,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_handled,
  output logic                         out_new_view,
  output logic                         out_page_hit,
  output logic                         out_storm_alarm,
  output logic                         out_unreachable_alarm,
  output logic [npfvs_pkg::STAT_W-1:0] out_command_status
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;

  // Latched input word
  logic [npfvs_pkg::CMD_W-1:0]  cmd_r;
  logic [npfvs_pkg::CPU_W-1:0]  cpu_r;
  logic [npfvs_pkg::ADDR_W-1:0] addr_r;
  logic                         fetch_r;
  logic                         write_r;

  // Output register
  logic                         out_valid_r;
  logic                         handled_r;
  logic                         view_r;
  logic                         hit_r;
  logic                         storm_r;
  logic                         unreach_r;
  logic [npfvs_pkg::STAT_W-1:0] status_r;

  // Per-CPU valid bits: an entry never written reads as its reset value
  logic [npfvs_pkg::CPU_COUNT-1:0] cpu_vld_r;

  logic                         accept;
  logic                         fire;
  logic                         cpu_ok;
  logic [npfvs_pkg::CPU_IW-1:0] ram_raddr;
  logic [npfvs_pkg::CPU_IW-1:0] cpu_idx;
  npfvs_pkg::cpu_ent_t          ram_rdata;
  npfvs_pkg::cpu_ent_t          ent;
  npfvs_pkg::cpu_ent_t          ent_nxt;
  logic                         ram_we;
  npfvs_pkg::watch_look_t       look;
  npfvs_pkg::watch_edit_t       edit;

  logic                         handled_nxt;
  logic                         view_nxt;
  logic                         storm_nxt;
  logic                         unreach_nxt;
  logic [npfvs_pkg::STAT_W-1:0] status_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  // Finish the word only when the output register is free or being drained
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign cpu_idx   = cpu_r[npfvs_pkg::CPU_IW-1:0];
  // Hold the read address on the latched processor while the word waits
  assign ram_raddr = in_ready ? in_cpu_index[npfvs_pkg::CPU_IW-1:0] : cpu_idx;
  assign cpu_ok    = ({1'b0, cpu_r} < (npfvs_pkg::CPU_W + 1)'(npfvs_pkg::CPU_COUNT));

  npfvs_ram #(
    .WIDTH ($bits(npfvs_pkg::cpu_ent_t)),
    .DEPTH (npfvs_pkg::CPU_COUNT)
  ) u_cpu_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cpu_idx),
    .wdata (ent_nxt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  npfvs_watch u_watch (
    .clk   (clk),
    .rst_n (rst_n),
    .page  (addr_r[npfvs_pkg::ADDR_W-1:npfvs_pkg::OFFS_W]),
    .edit  (edit),
    .look  (look)
  );

  // Update rules for one word; the RAM word read at accept is valid in S_EXEC
  always_comb begin
    ent         = cpu_vld_r[cpu_idx] ? ram_rdata : '0;
    ent_nxt     = ent;
    ram_we      = 1'b0;
    handled_nxt = 1'b0;
    storm_nxt   = 1'b0;
    unreach_nxt = 1'b0;
    status_nxt  = npfvs_pkg::ST_OK;
    edit.add    = 1'b0;
    edit.remove = 1'b0;

    unique case (cmd_r)
      npfvs_pkg::CMD_FAULT: begin
        if (cpu_ok && !look.empty) begin
          ram_we = fire;
          // Repeat tracking: saturate at the storm limit, alarm on reaching it
          if (ent.last_addr == addr_r) begin
            if (ent.cnt < npfvs_pkg::CNT_W'(npfvs_pkg::STORM_LIMIT)) begin
              ent_nxt.cnt = ent.cnt + npfvs_pkg::CNT_W'(1);
              storm_nxt   = (ent_nxt.cnt == npfvs_pkg::CNT_W'(npfvs_pkg::STORM_LIMIT));
            end
          end else begin
            ent_nxt.last_addr = addr_r;
            ent_nxt.cnt       = '0;
          end
          // View switch; fetch wins when both fault bits are set
          if (fetch_r) begin
            if (look.hit) begin
              ent_nxt.view = ~ent.view;
              unreach_nxt  = ent.view;
              handled_nxt  = 1'b1;
            end else if (ent.view) begin
              ent_nxt.view = 1'b0;
              handled_nxt  = 1'b1;
            end
          end else if (look.hit && write_r && ent.view) begin
            ent_nxt.view = 1'b0;
            handled_nxt  = 1'b1;
          end
        end
      end
      npfvs_pkg::CMD_ADD: begin
        edit.add   = fire;
        status_nxt = (look.hit || look.full) ? npfvs_pkg::ST_FULL_DUP : npfvs_pkg::ST_OK;
      end
      npfvs_pkg::CMD_REMOVE: begin
        edit.remove = fire;
        status_nxt  = look.hit ? npfvs_pkg::ST_OK : npfvs_pkg::ST_NOT_FOUND;
      end
      default: begin
        // Unknown command: no state change, report view and hit with an OK status
      end
    endcase

    view_nxt = cpu_ok ? ent_nxt.view : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cpu_vld_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        cpu_vld_r[cpu_idx] <= 1'b1;
      end
    end
  end

  // Payload registers: hold the input word, load results on fire
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      cpu_r   <= in_cpu_index;
      addr_r  <= in_guest_address;
      fetch_r <= in_fault_is_fetch;
      write_r <= in_fault_is_write;
    end
    if (fire) begin
      handled_r <= handled_nxt;
      view_r    <= view_nxt;
      hit_r     <= look.hit;
      storm_r   <= storm_nxt;
      unreach_r <= unreach_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_handled           = handled_r;
  assign out_new_view          = view_r;
  assign out_page_hit          = hit_r;
  assign out_storm_alarm       = storm_r;
  assign out_unreachable_alarm = unreach_r;
  assign out_command_status    = status_r;

  // One word at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("accepted a word while another was in flight");

  // Command failures never come with a handled fault
  a_status_not_handled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_status != npfvs_pkg::ST_OK) |-> !out_handled)
    else $error("handled result carries a command error");

  // Unreachable case always switches back to primary on a watched page
  a_unreach_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable_alarm |-> out_handled && out_page_hit && !out_new_view)
    else $error("unreachable alarm with inconsistent result");

  // A result is only produced after the RAM read cycle
  a_fire_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> $past(accept) || $past(state_r == S_EXEC))
    else $error("result produced without a preceding read");

endmodule
